// File: design/tremolo_lfo_gain_top_macros.svh
// assertion macros shared by the tremolo checker
`ifndef TREMOLO_LFO_GAIN_TOP_MACROS_SVH
`define TREMOLO_LFO_GAIN_TOP_MACROS_SVH

// implication into the next cycle, off while in reset
`define TLG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication into the next cycle, also checked across reset
`define TLG_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tlg_pkg.sv
// package: shared types and constants of the stereo tremolo
`default_nettype none
package tlg_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 17;
  localparam int DEPTH_BITS  = 17;
  localparam int INC_BITS    = 31;
  localparam int PHASE_BITS  = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 31;

  localparam logic [GAIN_BITS-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_INC  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SQUARE     = 2'd2;

  localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 17'd45875;
  localparam logic [INC_BITS-1:0]   INC_RESET   = 31'd536871;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
  } tlg_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
  } tlg_out_t;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth;
    logic [INC_BITS-1:0]   phase_increment;
    logic                  square_mode;
  } tlg_cfg_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic mul;
  } tlg_ctl_t;

endpackage
`default_nettype wire

// File: design/tlg_lfo.sv
// lfo: phase accumulator, raised-cosine rom and gain product
`default_nettype none
module tlg_lfo
  import tlg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tlg_ctl_t             ctl,
  input  wire tlg_cfg_t             cfg,
  output logic [GAIN_BITS-1:0]      gain
);

  localparam int TableSize = 1 << SINE_TABLE_BITS;
  localparam logic [63:0] PiQ30 = 64'd3373259426;

  // round(65536 * sin^2(pi*k/N)), taylor series in q30
  function automatic logic [GAIN_BITS-1:0] rc_value(input int unsigned k);
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] sq;
    logic [63:0] v;
    logic signed [63:0] sum;
    m = (k <= TableSize / 2) ? 64'(k) : 64'(TableSize - k);
    x = (PiQ30 * m) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    s = $unsigned(sum);
    sq = (s * s) >> 30;
    v = (sq + 64'd8192) >> 14;
    if (v > 64'd65536) begin
      v = 64'd65536;
    end
    return v[GAIN_BITS-1:0];
  endfunction

  logic [GAIN_BITS-1:0] rom_w [TableSize];

  for (genvar k = 0; k < TableSize; k++) begin : g_rom
    localparam logic [GAIN_BITS-1:0] Entry = rc_value(k);
    assign rom_w[k] = Entry;
  end

  logic [PHASE_BITS-1:0]      phase_r;
  logic [GAIN_BITS-1:0]       rom_q_r;
  logic                       half_r;
  logic [2*GAIN_BITS-2:0]     prod_r;
  logic [SINE_TABLE_BITS-1:0] rom_idx;
  logic [GAIN_BITS-1:0]       depth_sat;
  logic [GAIN_BITS-1:0]       lfo;

  assign rom_idx = phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];

  // any depth with bit 16 set is at or above full
  assign depth_sat = cfg.depth[DEPTH_BITS-1] ? ONE_Q16 : cfg.depth;

  always_comb begin
    if (cfg.square_mode) begin
      lfo = half_r ? ONE_Q16 : '0;
    end else begin
      lfo = rom_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (ctl.load) begin
      phase_r <= phase_r + {1'b0, cfg.phase_increment};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rom_q_r <= rom_w[rom_idx];
      half_r  <= phase_r[PHASE_BITS-1];
    end
    if (ctl.calc) begin
      prod_r <= {{(GAIN_BITS-1){1'b0}}, depth_sat} * {{(GAIN_BITS-1){1'b0}}, lfo};
    end
  end

  assign gain = ONE_Q16 - prod_r[2*GAIN_BITS-2:16];

endmodule
`default_nettype wire

// File: design/tlg_lane.sv
// lane: one channel's sample times gain with floor shift
`default_nettype none
module tlg_lane
  import tlg_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic [GAIN_BITS-1:0]          gain,
  output logic signed [SAMPLE_BITS-1:0]      result
);

  localparam int ProdBits = SAMPLE_BITS + GAIN_BITS + 1;

  logic signed [ProdBits-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= sample * $signed({1'b0, gain});
    end
  end

  // arithmetic shift by 16 rounds toward minus infinity
  assign result = prod_r[SAMPLE_BITS+15:16];

endmodule
`default_nettype wire

// File: design/tremolo_lfo_gain_top.sv
// Stereo tremolo: one frame per item, a shared lfo gain applied by two lanes.
// From input accept to output valid: lfo rom read, gain product, lane multiply and
// output load run one after another for each frame, the output load waiting while
// the output is full; no new frame is taken until the last one is loaded out.
// Reset (synchronous, rst_n low): phase to zero, config registers to their defaults,
// output empty, input ready.
`default_nettype none
module tremolo_lfo_gain_top
  import tlg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire tlg_in_t                  in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output tlg_out_t                      out_data,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LFO  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_OUT  = 4'b1000
  } tlg_state_t;

  tlg_state_t state_r, state_nxt;
  tlg_cfg_t   cfg_r;
  tlg_in_t    in_r;
  tlg_out_t   out_r;
  tlg_out_t   lanes;
  logic       out_valid_r;
  logic       out_free;
  tlg_ctl_t   ctl;
  logic [GAIN_BITS-1:0] gain;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth           <= DEPTH_RESET;
      cfg_r.phase_increment <= INC_RESET;
      cfg_r.square_mode     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEPTH:     cfg_r.depth           <= cfg_wdata[DEPTH_BITS-1:0];
        CFG_PHASE_INC: cfg_r.phase_increment <= cfg_wdata[INC_BITS-1:0];
        CFG_SQUARE:    cfg_r.square_mode     <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_LFO;
        end
      end
      ST_LFO: begin
        ctl.calc  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      in_r <= in_data;
    end
    if (state_r == ST_OUT && out_free) begin
      out_r <= lanes;
    end
  end

  tlg_lfo #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_lfo (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .cfg  (cfg_r),
    .gain (gain)
  );

  tlg_lane u_lane_left (
    .clk   (clk),
    .en    (ctl.mul),
    .sample(in_r.in_left),
    .gain  (gain),
    .result(lanes.out_left)
  );

  tlg_lane u_lane_right (
    .clk   (clk),
    .en    (ctl.mul),
    .sample(in_r.in_right),
    .gain  (gain),
    .result(lanes.out_right)
  );

endmodule
`default_nettype wire

// File: design/tlg_checker.sv
// checker: port-level properties of the tremolo, bound to the top level
`default_nettype none
`include "tremolo_lfo_gain_top_macros.svh"
module tlg_checker
  import tlg_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire tlg_out_t out_data
);

  // coming out of reset the block is empty and takes input
  `TLG_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid && in_ready, "not empty after reset")

  // one frame at a time: an accepted word closes the input
  `TLG_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input open while busy")

  // a frame passes the lfo, multiply and output states first, so no result right behind an accept
  `TLG_ASSERT_NEXT(a_no_early_out, in_valid && in_ready && !out_valid, !out_valid,
                   "result too early")

  // a stalled result word holds
  `TLG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data),
                   "stalled output changed")

endmodule

bind tremolo_lfo_gain_top tlg_checker u_tlg_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire
